// ===== hdl/frame_link_receiver_with_command_pulses_unit_assert.svh =====
// Assertion macros shared by the frame link receiver modules.
`ifndef FRAME_LINK_RECEIVER_WITH_COMMAND_PULSES_UNIT_ASSERT_SVH
`define FRAME_LINK_RECEIVER_WITH_COMMAND_PULSES_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FLR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flr: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flr: next-cycle check failed");

`endif

// ===== hdl/flr_pkg.sv =====
// Types and constants of the frame link receiver.
package flr_pkg;

  // Link word and field geometry
  localparam int DW           = 10;
  localparam int SIDE_RESET   = 40;
  localparam int SIDE_W       = 7;
  localparam int IDX_W        = 9;
  localparam int NUM_BUFS     = 3;
  localparam int BUF_W        = 2;

  // Frame length: ceil(side^2 / 10) by reciprocal multiply (exact below 2^14)
  localparam int SQ_W        = 2 * SIDE_W;
  localparam int RECIP_W     = 13;
  localparam int RECIP       = 6554;
  localparam int RECIP_SHIFT = 16;
  localparam int RAW_W       = 11;

  // Request kinds
  typedef enum logic [2:0] {
    KIND_STROBE = 3'd0,
    KIND_PAUSE  = 3'd1,
    KIND_START  = 3'd2,
    KIND_RESET  = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  // Per-request status from control to the result pipeline
  typedef struct packed {
    logic       link_out;
    logic       frame_done;
    logic [2:0] link_phase;
    logic       rd_hit;
  } flr_res_t;

endpackage

// ===== hdl/flr_in_if.sv =====
// Request channel of the frame link receiver.
interface flr_in_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 kind;
  logic [flr_pkg::DW-1:0]     data_bits;
  logic [flr_pkg::IDX_W-1:0]  word_index;

  modport source (output valid, output kind, output data_bits, output word_index,
                  input ready);
  modport sink   (input valid, input kind, input data_bits, input word_index,
                  output ready);
endinterface

// ===== hdl/flr_out_if.sv =====
// Result channel of the frame link receiver.
interface flr_out_if;
  logic                   valid;
  logic                   ready;
  logic                   link_out;
  logic                   frame_done;
  logic [flr_pkg::DW-1:0] read_word;
  logic [2:0]             link_phase;

  modport source (output valid, output link_out, output frame_done, output read_word,
                  output link_phase, input ready);
  modport sink   (input valid, input link_out, input frame_done, input read_word,
                  input link_phase, output ready);
endinterface

// ===== hdl/flr_store.sv =====
// Frame store: three buffers of link words, one write and one registered read port.
module flr_store #(
  parameter int MAX_WORDS = 512
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [flr_pkg::BUF_W-1:0]       wbuf,
  input  logic [$clog2(MAX_WORDS)-1:0]    widx,
  input  logic [flr_pkg::DW-1:0]          wdata,
  input  logic                            re,
  input  logic [flr_pkg::BUF_W-1:0]       rbuf,
  input  logic [$clog2(MAX_WORDS)-1:0]    ridx,
  output logic [flr_pkg::DW-1:0]          rdata
);
  import flr_pkg::*;

  logic [DW-1:0] mem_r [NUM_BUFS][MAX_WORDS];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wbuf][widx] <= wdata;
    end
  end

  // Read port, registered, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[rbuf][ridx];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/flr_ctrl.sv =====
// Link control: phase sequencer, request latches, buffer roles and fill marks.
`include "frame_link_receiver_with_command_pulses_unit_assert.svh"

module flr_ctrl #(
  parameter int MAX_WORDS = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [flr_pkg::SIDE_W-1:0]      cfg_wdata,
  input  logic                            acc,
  input  logic [2:0]                      kind,
  input  logic [flr_pkg::DW-1:0]          data_bits,
  input  logic [flr_pkg::IDX_W-1:0]       word_index,
  output logic                            mem_we,
  output logic [flr_pkg::BUF_W-1:0]       mem_wbuf,
  output logic [$clog2(MAX_WORDS)-1:0]    mem_widx,
  output logic [flr_pkg::DW-1:0]          mem_wdata,
  output logic                            mem_re,
  output logic [flr_pkg::BUF_W-1:0]       mem_rbuf,
  output logic [$clog2(MAX_WORDS)-1:0]    mem_ridx,
  output flr_pkg::flr_res_t               res
);
  import flr_pkg::*;

  localparam int SW  = $clog2(MAX_WORDS + 1);
  localparam int IW  = $clog2(MAX_WORDS);
  localparam int CW  = (SW > RAW_W) ? SW : RAW_W;
  localparam int XW  = (SW > IDX_W) ? SW : IDX_W;
  localparam int PW  = SQ_W + RECIP_W + 1;
  localparam logic [SW-1:0] FILL_MAX = SW'(MAX_WORDS);

  typedef enum logic [2:0] {
    PH_RUNNING   = 3'd0,
    PH_RECV      = 3'd1,
    PH_PAUSED    = 3'd2,
    PH_STARTING  = 3'd3,
    PH_PAUSING   = 3'd4,
    PH_RESETTING = 3'd5
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [SW-1:0]    step_r, step_nxt;
  logic             pause_pend_r, pause_pend_nxt;
  logic             start_pend_r, start_pend_nxt;
  logic             reset_pend_r, reset_pend_nxt;
  logic             frame_pend_r, frame_pend_nxt;
  logic             level_r, level_nxt;
  logic [BUF_W-1:0] recv_r, recv_nxt;
  logic [BUF_W-1:0] pend_r, pend_nxt;
  logic [BUF_W-1:0] disp_r, disp_nxt;
  logic [SW-1:0]    fill_recv_r, fill_recv_nxt;
  logic [SW-1:0]    fill_pend_r, fill_pend_nxt;
  logic [SW-1:0]    fill_disp_r, fill_disp_nxt;
  logic [SQ_W-1:0]  sq_r;

  logic [SQ_W:0]    sq_rnd;
  logic [PW-1:0]    words_prod;
  logic [RAW_W-1:0] words_raw;
  logic [CW-1:0]    words_ext;
  logic [SW-1:0]    words;
  logic [SW-1:0]    step_inc;
  logic [SW-1:0]    fill_new;
  logic             swap;
  logic [SW-1:0]    fill_sel;
  logic             hit;
  logic             done;

  // Frame length in words from the squared side: round up, at least one, at most MAX_WORDS
  always_comb begin
    sq_rnd     = {1'b0, sq_r} + (SQ_W + 1)'(DW - 1);
    words_prod = PW'(sq_rnd) * PW'(RECIP);
    words_raw  = words_prod[RECIP_SHIFT +: RAW_W];
    words_ext  = CW'(words_raw);
    if (words_raw == '0) begin
      words = SW'(1);
    end else if (words_ext > CW'(MAX_WORDS)) begin
      words = SW'(MAX_WORDS);
    end else begin
      words = SW'(words_ext);
    end
  end

  // Next state for the request in hand
  always_comb begin
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    pause_pend_nxt = pause_pend_r;
    start_pend_nxt = start_pend_r;
    reset_pend_nxt = reset_pend_r;
    frame_pend_nxt = frame_pend_r;
    level_nxt      = level_r;
    recv_nxt       = recv_r;
    pend_nxt       = pend_r;
    disp_nxt       = disp_r;
    fill_recv_nxt  = fill_recv_r;
    fill_pend_nxt  = fill_pend_r;
    fill_disp_nxt  = fill_disp_r;
    done           = 1'b0;
    mem_we         = 1'b0;
    mem_wbuf       = recv_r;
    mem_widx       = IW'(step_r);
    mem_wdata      = data_bits;
    step_inc       = SW'(step_r + SW'(1));
    fill_new       = (step_inc > fill_recv_r) ? step_inc : fill_recv_r;

    // Display swap on a read of word zero with a frame waiting
    swap     = (word_index == '0) && frame_pend_r;
    fill_sel = swap ? fill_pend_r : fill_disp_r;
    mem_rbuf = swap ? pend_r : disp_r;
    mem_ridx = IW'(word_index);
    hit      = (XW'(word_index) < XW'(words)) && (XW'(word_index) < XW'(fill_sel));
    mem_re   = 1'b0;

    if (acc) begin
      unique case (kind)
        KIND_STROBE: begin
          unique case (phase_r)
            PH_RECV: begin
              start_pend_nxt = 1'b0;
              mem_we         = 1'b1;
              if (step_inc >= words) begin
                recv_nxt       = pend_r;
                pend_nxt       = recv_r;
                fill_recv_nxt  = fill_pend_r;
                fill_pend_nxt  = fill_new;
                frame_pend_nxt = 1'b1;
                phase_nxt      = PH_RUNNING;
                step_nxt       = '0;
                done           = 1'b1;
              end else begin
                step_nxt      = step_inc;
                fill_recv_nxt = fill_new;
              end
            end
            PH_RUNNING: begin
              start_pend_nxt = 1'b0;
              level_nxt      = 1'b0;
              if (data_bits[0]) begin
                phase_nxt = PH_RECV;
                step_nxt  = '0;
              end else if (pause_pend_r) begin
                pause_pend_nxt = 1'b0;
                phase_nxt      = PH_PAUSING;
                step_nxt       = '0;
              end
            end
            PH_STARTING: begin
              level_nxt = 1'b1;
              if (step_r >= SW'(2)) begin
                step_nxt  = '0;
                phase_nxt = PH_RUNNING;
              end else begin
                step_nxt = step_inc;
              end
            end
            PH_PAUSING: begin
              if (step_r == '0) begin
                level_nxt = 1'b1;
                step_nxt  = SW'(1);
              end else begin
                level_nxt = 1'b0;
                step_nxt  = '0;
                phase_nxt = PH_PAUSED;
              end
            end
            PH_PAUSED: begin
              if (reset_pend_r) begin
                phase_nxt      = PH_RESETTING;
                step_nxt       = '0;
                reset_pend_nxt = 1'b0;
              end else if (start_pend_r) begin
                phase_nxt      = PH_STARTING;
                step_nxt       = '0;
                start_pend_nxt = 1'b0;
              end
            end
            PH_RESETTING: begin
              // H,L,H,L then back to paused
              if (step_r >= SW'(3)) begin
                level_nxt = 1'b0;
                phase_nxt = PH_PAUSED;
                step_nxt  = '0;
              end else begin
                level_nxt = ~step_r[0];
                step_nxt  = step_inc;
              end
            end
            default: begin
            end
          endcase
        end
        KIND_PAUSE: begin
          pause_pend_nxt = 1'b1;
          start_pend_nxt = 1'b0;
        end
        KIND_START: begin
          start_pend_nxt = 1'b1;
          pause_pend_nxt = 1'b0;
        end
        KIND_RESET: begin
          reset_pend_nxt = 1'b1;
        end
        KIND_READ: begin
          if (swap) begin
            disp_nxt       = pend_r;
            pend_nxt       = disp_r;
            fill_disp_nxt  = fill_pend_r;
            fill_pend_nxt  = fill_disp_r;
            frame_pend_nxt = 1'b0;
          end
          mem_re = hit;
        end
        default: begin
        end
      endcase
    end

    res.link_out   = level_nxt;
    res.frame_done = done;
    res.link_phase = phase_nxt;
    res.rd_hit     = mem_re;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RUNNING;
      step_r       <= '0;
      pause_pend_r <= 1'b0;
      start_pend_r <= 1'b0;
      reset_pend_r <= 1'b0;
      frame_pend_r <= 1'b0;
      level_r      <= 1'b0;
      recv_r       <= BUF_W'(0);
      pend_r       <= BUF_W'(1);
      disp_r       <= BUF_W'(2);
      fill_recv_r  <= '0;
      fill_pend_r  <= '0;
      fill_disp_r  <= '0;
    end else begin
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      pause_pend_r <= pause_pend_nxt;
      start_pend_r <= start_pend_nxt;
      reset_pend_r <= reset_pend_nxt;
      frame_pend_r <= frame_pend_nxt;
      level_r      <= level_nxt;
      recv_r       <= recv_nxt;
      pend_r       <= pend_nxt;
      disp_r       <= disp_nxt;
      fill_recv_r  <= fill_recv_nxt;
      fill_pend_r  <= fill_pend_nxt;
      fill_disp_r  <= fill_disp_nxt;
    end
  end

  // Field side register, kept as its square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= SQ_W'(SIDE_RESET * SIDE_RESET);
    end else if (cfg_we) begin
      sq_r <= SQ_W'(cfg_wdata) * SQ_W'(cfg_wdata);
    end
  end

  `FLR_ASSERT_IMPL(a_roles_distinct, 1'b1, recv_r != pend_r && recv_r != disp_r && pend_r != disp_r)
  `FLR_ASSERT_IMPL(a_fill_bound, 1'b1, fill_recv_r <= FILL_MAX && fill_pend_r <= FILL_MAX)
  `FLR_ASSERT_IMPL(a_disp_fill_bound, 1'b1, fill_disp_r <= FILL_MAX)
  `FLR_ASSERT_IMPL(a_write_not_display, mem_we, mem_wbuf != disp_r && !mem_re)
  `FLR_ASSERT_NEXT(a_done_to_running, acc && done, phase_r == PH_RUNNING && frame_pend_r)

endmodule

// ===== hdl/frame_link_receiver_with_command_pulses_unit.sv =====
// Frame link receiver with command pulses: top level and result pipeline.
//
// Requests arrive on in_chan (valid/ready): strobe edges with ten data pins,
// pause/start/reset requests and display reads. Every accepted request gives
// exactly one result on out_chan (valid/ready): command output level, frame
// done flag, display word and link phase.
// The configuration port (cfg_we, cfg_wdata) sets the field side; write it
// only while no request is in flight.
// An accepted request is held in the read stage, where the frame store read
// is done, and then in the output register. Throughput: one request per
// cycle while out_chan is not stalled; the frame store takes one write and
// one read each cycle and a request needs at most one of them.
// When out_chan stalls, one result waits in the output register and one more
// in the read stage; in_chan.ready drops only when both are full.
// After rst_n the link is running, no requests are latched, the side is 40
// and all three buffers read as zero. Per-buffer fill marks stand for the
// cleared store, so there is no clearing pass and requests are taken at once.
`include "frame_link_receiver_with_command_pulses_unit_assert.svh"

module frame_link_receiver_with_command_pulses_unit #(
  parameter int MAX_WORDS = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [flr_pkg::SIDE_W-1:0]  cfg_wdata,
  flr_in_if.sink                      in_chan,
  flr_out_if.source                   out_chan
);
  import flr_pkg::*;

  localparam int IW = $clog2(MAX_WORDS);

  logic             in_acc;
  logic             s1_adv;
  logic             mem_we;
  logic [BUF_W-1:0] mem_wbuf;
  logic [IW-1:0]    mem_widx;
  logic [DW-1:0]    mem_wdata;
  logic             mem_re;
  logic [BUF_W-1:0] mem_rbuf;
  logic [IW-1:0]    mem_ridx;
  logic [DW-1:0]    mem_rdata;
  flr_res_t         res;

  logic             s1_valid_r;
  flr_res_t         s1_res_r;
  logic             out_valid_r;
  logic             out_link_r;
  logic             out_done_r;
  logic [DW-1:0]    out_word_r;
  logic [2:0]       out_phase_r;

  // Handshake
  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  flr_ctrl #(.MAX_WORDS(MAX_WORDS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .acc        (in_acc),
    .kind       (in_chan.kind),
    .data_bits  (in_chan.data_bits),
    .word_index (in_chan.word_index),
    .mem_we     (mem_we),
    .mem_wbuf   (mem_wbuf),
    .mem_widx   (mem_widx),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_rbuf   (mem_rbuf),
    .mem_ridx   (mem_ridx),
    .res        (res)
  );

  flr_store #(.MAX_WORDS(MAX_WORDS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .wbuf  (mem_wbuf),
    .widx  (mem_widx),
    .wdata (mem_wdata),
    .re    (mem_re),
    .rbuf  (mem_rbuf),
    .ridx  (mem_ridx),
    .rdata (mem_rdata)
  );

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_acc;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Read stage and output register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= res;
    end
    if (s1_adv && s1_valid_r) begin
      out_link_r  <= s1_res_r.link_out;
      out_done_r  <= s1_res_r.frame_done;
      out_phase_r <= s1_res_r.link_phase;
      out_word_r  <= s1_res_r.rd_hit ? mem_rdata : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.link_out   = out_link_r;
  assign out_chan.frame_done = out_done_r;
  assign out_chan.read_word  = out_word_r;
  assign out_chan.link_phase = out_phase_r;

  `FLR_ASSERT_NEXT(a_acc_fills_s1, in_acc, s1_valid_r)
  `FLR_ASSERT_NEXT(a_rdata_held, s1_valid_r && !s1_adv, $stable(mem_rdata))
  `FLR_ASSERT_NEXT(a_s1_drains, s1_valid_r && s1_adv, out_valid_r)

endmodule

// ===== dv/flr_frame_checker.sv =====
// Frame link receiver checker: watches both channels, predicts each result and compares.
module flr_frame_checker #(
  parameter int FRAME_WORDS = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [flr_pkg::SIDE_W-1:0] cfg_wdata,
  flr_in_if                          req_mon,
  flr_out_if                         res_mon,
  output int unsigned                fail_count,
  output int unsigned                awaiting,
  output int unsigned                words_in_frame,
  output logic                       link_running,
  output logic                       link_receiving
);
  timeunit 1ns;
  timeprecision 1ps;
  import flr_pkg::*;

  typedef enum logic [2:0] {
    LINK_RUNNING   = 3'd0,
    LINK_RECEIVING = 3'd1,
    LINK_PAUSED    = 3'd2,
    LINK_STARTING  = 3'd3,
    LINK_PAUSING   = 3'd4,
    LINK_RESETTING = 3'd5
  } link_phase_t;

  typedef struct packed {
    logic          link_out;
    logic          frame_done;
    logic [DW-1:0] read_word;
    logic [2:0]    link_phase;
  } link_result_t;

  // Mirror of the link state
  link_phase_t       phase_q;
  int unsigned       step_q;
  logic              pause_latched;
  logic              start_latched;
  logic              reset_latched;
  logic              frame_ready;
  logic              level_q;
  logic [BUF_W-1:0]  recv_buf;
  logic [BUF_W-1:0]  pend_buf;
  logic [BUF_W-1:0]  disp_buf;
  logic [SIDE_W-1:0] side_q;
  logic [DW-1:0]     buf_mem [NUM_BUFS][FRAME_WORDS];
  link_result_t      expected_q[$];

  // Words per frame: ceil(side^2 / 10), at least one, at most the buffer depth
  function automatic int unsigned frame_length(int unsigned side);
    int unsigned n;
    n = (side * side + DW - 1) / DW;
    if (n == 0) n = 1;
    if (n > FRAME_WORDS) n = FRAME_WORDS;
    return n;
  endfunction

  // Advance the link by one request and return the result it should give
  function automatic link_result_t predict_result(logic [2:0] kind, logic [DW-1:0] data,
                                                  logic [IDX_W-1:0] index);
    link_result_t     r;
    logic [BUF_W-1:0] spare;
    int unsigned      flen;
    r = '0;
    flen = frame_length(side_q);
    case (kind)
      KIND_STROBE: begin
        case (phase_q)
          LINK_RECEIVING: begin
            start_latched = 1'b0;
            if (step_q < FRAME_WORDS) buf_mem[recv_buf][step_q] = data;
            step_q++;
            // last word in: receive buffer becomes the pending frame
            if (step_q >= flen) begin
              spare = recv_buf;
              recv_buf = pend_buf;
              pend_buf = spare;
              frame_ready = 1'b1;
              phase_q = LINK_RUNNING;
              step_q = 0;
              r.frame_done = 1'b1;
            end
          end
          LINK_RUNNING: begin
            start_latched = 1'b0;
            level_q = 1'b0;
            if (data[0]) begin
              phase_q = LINK_RECEIVING;
              step_q = 0;
            end else if (pause_latched) begin
              pause_latched = 1'b0;
              phase_q = LINK_PAUSING;
              step_q = 0;
            end
          end
          LINK_STARTING: begin
            level_q = 1'b1;
            if (step_q >= 2) begin
              step_q = 0;
              phase_q = LINK_RUNNING;
            end else begin
              step_q++;
            end
          end
          LINK_PAUSING: begin
            if (step_q == 0) begin
              level_q = 1'b1;
              step_q = 1;
            end else begin
              level_q = 1'b0;
              step_q = 0;
              phase_q = LINK_PAUSED;
            end
          end
          LINK_PAUSED: begin
            if (reset_latched) begin
              phase_q = LINK_RESETTING;
              step_q = 0;
              reset_latched = 1'b0;
            end else if (start_latched) begin
              phase_q = LINK_STARTING;
              step_q = 0;
              start_latched = 1'b0;
            end
          end
          default: begin
            // reset train H,L,H,L then back to paused
            if (step_q >= 3) begin
              level_q = 1'b0;
              phase_q = LINK_PAUSED;
              step_q = 0;
            end else begin
              level_q = (step_q % 2 == 0);
              step_q++;
            end
          end
        endcase
      end
      KIND_PAUSE: begin
        pause_latched = 1'b1;
        start_latched = 1'b0;
      end
      KIND_START: begin
        start_latched = 1'b1;
        pause_latched = 1'b0;
      end
      KIND_RESET: reset_latched = 1'b1;
      KIND_READ: begin
        // word zero pulls a waiting frame into display
        if (index == 0 && frame_ready) begin
          spare = disp_buf;
          disp_buf = pend_buf;
          pend_buf = spare;
          frame_ready = 1'b0;
        end
        if (index < flen && index < FRAME_WORDS) r.read_word = buf_mem[disp_buf][index];
      end
      default: ;
    endcase
    r.link_out = level_q;
    r.link_phase = phase_q;
    return r;
  endfunction

  function automatic bit field_differs(string field, logic [DW-1:0] want, logic [DW-1:0] got);
    if (got === want) return 1'b0;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    return 1'b1;
  endfunction

  // Requests and results are taken at the rising edge, before the block updates
  always @(posedge clk) begin : watch
    link_result_t got;
    link_result_t want;
    if (!rst_n) begin
      phase_q = LINK_RUNNING;
      step_q = 0;
      pause_latched = 1'b0;
      start_latched = 1'b0;
      reset_latched = 1'b0;
      frame_ready = 1'b0;
      level_q = 1'b0;
      recv_buf = 2'd0;
      pend_buf = 2'd1;
      disp_buf = 2'd2;
      side_q = SIDE_W'(SIDE_RESET);
      foreach (buf_mem[b, w]) buf_mem[b][w] = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) side_q = cfg_wdata;
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(predict_result(req_mon.kind, req_mon.data_bits,
                                            req_mon.word_index));
      if (res_mon.valid && res_mon.ready) begin
        got.link_out = res_mon.link_out;
        got.frame_done = res_mon.frame_done;
        got.read_word = res_mon.read_word;
        got.link_phase = res_mon.link_phase;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none actual %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          if (field_differs("link_out", DW'(want.link_out), DW'(got.link_out)) |
              field_differs("frame_done", DW'(want.frame_done), DW'(got.frame_done)) |
              field_differs("read_word", want.read_word, got.read_word) |
              field_differs("link_phase", DW'(want.link_phase), DW'(got.link_phase)))
            fail_count++;
        end
      end
    end
    awaiting = expected_q.size();
    words_in_frame = frame_length(side_q);
    link_running = (phase_q == LINK_RUNNING);
    link_receiving = (phase_q == LINK_RECEIVING);
  end

endmodule

// ===== dv/tb_frame_link_receiver_with_command_pulses_unit.sv =====
// Frame link receiver testbench top: clock, reset, request stimulus, result stalls and verdict.
module tb_frame_link_receiver_with_command_pulses_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import flr_pkg::*;

  localparam int unsigned   CYCLE_LIMIT     = 400000;
  localparam int unsigned   SETTLE_CYCLES   = 6;
  localparam int unsigned   PHASE_ITEMS     = 22;
  localparam int unsigned   MID_FRAME_ITEMS = 60;
  localparam int unsigned   BIG_FRAME_ITEMS = 700;
  localparam logic [DW-1:0]    ALL_PINS  = '1;
  localparam logic [IDX_W-1:0] LAST_WORD = '1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [SIDE_W-1:0] cfg_wdata;
  bit                gaps_on = 1'b0;
  bit                stalls_on = 1'b0;
  int unsigned       fail_count;
  int unsigned       awaiting;
  int unsigned       words_in_frame;
  int unsigned       cycle_count;
  logic              link_running;
  logic              link_receiving;
  // field sides per phase; 70 is cut short so the next side ends its frame
  int unsigned       side_plan[10] = '{10, 0, 13, 70, 10, 127, 1, 23, 40, 10};

  always #5 clk = ~clk;

  flr_in_if  req_chan ();
  flr_out_if res_chan ();

  frame_link_receiver_with_command_pulses_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  flr_frame_checker frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req_mon       (req_chan),
    .res_mon       (res_chan),
    .fail_count    (fail_count),
    .awaiting      (awaiting),
    .words_in_frame(words_in_frame),
    .link_running  (link_running),
    .link_receiving(link_receiving)
  );

  // One request, with an occasional idle burst in front of it
  task automatic send_req(logic [2:0] kind, logic [DW-1:0] data, logic [IDX_W-1:0] index);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      req_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_chan.valid <= 1'b1;
    req_chan.kind <= kind;
    req_chan.data_bits <= data;
    req_chan.word_index <= index;
    do @(posedge clk); while (!req_chan.ready);
    @(negedge clk);
  endtask

  // Hold off until every result is back and the pipeline is empty
  task automatic settle();
    req_chan.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_side(logic [SIDE_W-1:0] side);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= side;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side back-pressure in random bursts
  initial begin : result_stalls
    int unsigned hold;
    hold = 0;
    res_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && stalls_on && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 19);
      if (hold != 0) begin
        hold--;
        res_chan.ready <= 1'b0;
      end else begin
        res_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned       budget;
    int unsigned       roll;
    int unsigned       pick;
    logic [DW-1:0]     data;
    logic [IDX_W-1:0]  index;
    logic [2:0]        odd_kind;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_chan.valid = 1'b0;
    req_chan.kind = KIND_STROBE;
    req_chan.data_bits = '0;
    req_chan.word_index = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Empty display after reset, then unknown kinds
    send_req(KIND_READ, '0, '0);
    for (int k = int'(KIND_READ) + 1; k < (1 << $bits(kind_t)); k++)
      send_req(3'(k), ALL_PINS, LAST_WORD);

    // Side zero: one-word frame, read past it, swap on word zero, read again
    write_side('0);
    send_req(KIND_STROBE, ALL_PINS, '0);
    send_req(KIND_STROBE, ALL_PINS, '0);
    send_req(KIND_READ, '0, IDX_W'(1));
    send_req(KIND_READ, '0, '0);
    send_req(KIND_READ, '0, '0);

    // Pause overridden by start, pause again, then the pause train
    send_req(KIND_PAUSE, '0, '0);
    send_req(KIND_START, '0, '0);
    send_req(KIND_PAUSE, '0, '0);
    repeat (3) send_req(KIND_STROBE, '0, '0);

    // Reset train with a start latched in the middle, then the start train
    send_req(KIND_RESET, '0, '0);
    repeat (2) send_req(KIND_STROBE, '0, '0);
    send_req(KIND_START, '0, '0);
    repeat (7) send_req(KIND_STROBE, '0, '0);
    send_req(KIND_READ, '0, LAST_WORD);

    // Random phases, one field side each; the last one runs without idling
    foreach (side_plan[p]) begin
      write_side(SIDE_W'(side_plan[p]));
      gaps_on = (p != $size(side_plan) - 1) && ($urandom_range(0, 3) != 0);
      stalls_on <= (p != $size(side_plan) - 1) && ($urandom_range(0, 3) != 0);
      budget = (side_plan[p] > 100) ? BIG_FRAME_ITEMS :
               (side_plan[p] > 50) ? MID_FRAME_ITEMS : PHASE_ITEMS;
      repeat (budget) begin
        roll = $urandom_range(0, 99);
        data = DW'($urandom());
        odd_kind = 3'($urandom_range(int'(KIND_READ) + 1, (1 << $bits(kind_t)) - 1));
        pick = $urandom_range(0, 99);
        if (pick < 40) index = '0;
        else if (pick < 75) index = IDX_W'($urandom_range(0, words_in_frame - 1));
        else index = IDX_W'($urandom());
        if (link_receiving) begin
          // mostly frame words, some requests in between
          if (roll < 88) send_req(KIND_STROBE, data, index);
          else if (roll < 92) send_req(KIND_READ, data, index);
          else if (roll < 95) send_req(KIND_PAUSE, data, index);
          else if (roll < 97) send_req(KIND_START, data, index);
          else if (roll < 99) send_req(KIND_RESET, data, index);
          else send_req(odd_kind, data, index);
        end else if (link_running) begin
          if (roll < 45) send_req(KIND_STROBE, data | DW'(1), index);
          else if (roll < 55) send_req(KIND_STROBE, data & ~DW'(1), index);
          else if (roll < 75) send_req(KIND_READ, data, index);
          else if (roll < 83) send_req(KIND_PAUSE, data, index);
          else if (roll < 88) send_req(KIND_START, data, index);
          else if (roll < 95) send_req(KIND_RESET, data, index);
          else send_req(odd_kind, data, index);
        end else begin
          // pulse trains and paused
          if (roll < 55) send_req(KIND_STROBE, data, index);
          else if (roll < 68) send_req(KIND_START, data, index);
          else if (roll < 78) send_req(KIND_RESET, data, index);
          else if (roll < 84) send_req(KIND_PAUSE, data, index);
          else if (roll < 96) send_req(KIND_READ, data, index);
          else send_req(odd_kind, data, index);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
